// File: design/sbt_pkg.sv
// shared types and constants for the spi master byte transfer unit
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package sbt_pkg;

  // word geometry
  localparam int BitsPerWord = 8;
  localparam int HalfCount   = 2 * BitsPerWord;
  localparam int HalfW       = $clog2(HalfCount);
  localparam int BitIdxW     = $clog2(BitsPerWord);

  // request type codes
  localparam logic ReqTransfer = 1'b0;
  localparam logic ReqSelect   = 1'b1;

  // configuration register indexes
  localparam int           CfgIdxW     = 8;
  localparam logic [7:0]   CfgPolarity = 8'd0;
  localparam logic [7:0]   CfgPhase    = 8'd1;
  localparam logic [7:0]   CfgHalfPer  = 8'd2;
  localparam logic [7:0]   HalfPerRst  = 8'd4;

  // input transaction
  typedef struct packed {
    logic       req_type;
    logic [7:0] tx_byte;
    logic       select_request;
    logic [7:0] miso_bits;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic       sck_level;
    logic       mosi_level;
    logic       cs_n_level;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       last;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic       is_select;
    logic [7:0] tx_byte;
    logic [7:0] miso_bits;
    logic       cs_n;
    logic       mosi_hold;
  } cmd_t;

  // configuration registers seen by the back end
  typedef struct packed {
    logic       cpol;
    logic       cpha;
    logic [7:0] half_period;
  } cfg_regs_t;

endpackage

`default_nettype wire

// File: design/spi_master_byte_transfer_unit.sv
// top level of the spi master byte transfer unit: config registers and wiring
// depends on sbt_pkg, sbt_front, sbt_queue, sbt_back
//
// usage:
//   input channel (in_push / in_full) takes one transaction per cycle while the
//   two-entry command queue has room. a byte transfer yields 16 half-bit pin
//   states, msb first; a chip-select request yields one pin state.
//   result channel (out_empty / out_pop) shows the oldest pin state while
//   out_empty is low. pin states are released at the pace of the configured
//   half period, timed from each pop (a half period of 0 acts as 1). an item
//   accepted into an idle block passes through the command queue and is then
//   loaded into the sequencer before its first state shows. the queue takes
//   new items while the half-bit sequencer is still working on a transfer.
//   the next command is loaded on the same edge that pops the last state.
//   a stalled receiver holds the current state; the queue then fills and
//   in_full rises. config writes (cfg_valid / cfg_ready, always ready) are
//   meant for idle periods. reset deselects, idles mosi low, empties the queue
//   and restores polarity 0, phase 0, half period 4.
`default_nettype none

module spi_master_byte_transfer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire sbt_pkg::in_item_t             in_item,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output sbt_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sbt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  sbt_pkg::cfg_regs_t cfg_r;
  sbt_pkg::cmd_t      front_cmd;
  sbt_pkg::cmd_t      q_data;
  logic               in_accept;
  logic               q_empty;
  logic               q_pop;
  logic               back_busy;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpol        <= 1'b0;
      cfg_r.cpha        <= 1'b0;
      cfg_r.half_period <= sbt_pkg::HalfPerRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbt_pkg::CfgPolarity: cfg_r.cpol        <= cfg_data[0];
        sbt_pkg::CfgPhase:    cfg_r.cpha        <= cfg_data[0];
        sbt_pkg::CfgHalfPer:  cfg_r.half_period <= cfg_data;
        default:              cfg_r             <= cfg_r;
      endcase
    end
  end

  // classify incoming transactions
  sbt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  // decoupling queue
  sbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (in_full),
    .empty     (q_empty)
  );

  // pin state sequencer
  sbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item),
    .busy      (back_busy)
  );

`ifndef ASSERT_OFF
  // an accepted transaction is held in the queue or in the sequencer
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (!q_empty || back_busy))
    else $error("accepted transaction lost");

  // a full queue only happens behind a busy sequencer
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> back_busy)
    else $error("queue full while sequencer idle");

  // received byte only on the final pin state
  a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.rx_valid) |-> out_item.last)
    else $error("rx_valid without last");

  // queue never drained into an idle-to-busy sequencer without data
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> back_busy)
    else $error("command load did not start sequencer");
`endif

endmodule

`default_nettype wire

// File: design/sbt_front.sv
// front end: accepts items, tracks select and held mosi, builds commands
// depends on sbt_pkg
`default_nettype none

module sbt_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire sbt_pkg::in_item_t item,
  output sbt_pkg::cmd_t         cmd
);

  logic select_active_r, select_active_nxt;
  logic mosi_pin_r, mosi_pin_nxt;

  // select and mosi bookkeeping in item order
  always_comb begin
    select_active_nxt = select_active_r;
    mosi_pin_nxt      = mosi_pin_r;
    if (item.req_type == sbt_pkg::ReqSelect) begin
      if (item.select_request != select_active_r) begin
        select_active_nxt = item.select_request;
        if (!item.select_request) begin
          mosi_pin_nxt = 1'b0;
        end
      end
    end else begin
      // mosi holds the last bit sent
      mosi_pin_nxt = item.tx_byte[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_active_r <= 1'b0;
      mosi_pin_r      <= 1'b0;
    end else if (accept) begin
      select_active_r <= select_active_nxt;
      mosi_pin_r      <= mosi_pin_nxt;
    end
  end

  // command for the back end
  always_comb begin
    cmd.is_select = (item.req_type == sbt_pkg::ReqSelect);
    cmd.tx_byte   = item.tx_byte;
    cmd.miso_bits = item.miso_bits;
    cmd.cs_n      = ~select_active_nxt;
    cmd.mosi_hold = mosi_pin_nxt;
  end

endmodule

`default_nettype wire

// File: design/sbt_queue.sv
// two-entry command queue between front and back end
// depends on sbt_pkg
`default_nettype none

module sbt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sbt_pkg::cmd_t push_data,
  input  wire logic          pop,
  output sbt_pkg::cmd_t      pop_data,
  output logic               full,
  output logic               empty
);

  sbt_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// File: design/sbt_back.sv
// back end: expands commands into half-bit pin states, paced by half period
// depends on sbt_pkg
`default_nettype none

module sbt_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbt_pkg::cfg_regs_t cfg,
  input  wire sbt_pkg::cmd_t     q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output sbt_pkg::out_item_t     out_item,
  output logic                   busy
);

  logic                      busy_r;
  sbt_pkg::cmd_t             cmd_r;
  logic [sbt_pkg::HalfW-1:0] half_r;
  logic [7:0]                timer_r;
  logic                      res_last;
  logic                      take;
  logic                      load;
  logic [sbt_pkg::BitIdxW-1:0] bit_sel;

  assign busy      = busy_r;
  assign out_empty = !(busy_r && (timer_r == 8'd0));
  assign take      = out_pop && !out_empty;
  assign res_last  = cmd_r.is_select || (half_r == sbt_pkg::HalfW'(sbt_pkg::HalfCount - 1));
  assign load      = !q_empty && (!busy_r || (take && res_last));
  assign q_pop     = load;
  assign bit_sel   = sbt_pkg::BitIdxW'(sbt_pkg::BitsPerWord - 1)
                   - half_r[sbt_pkg::HalfW-1:1];

  // sequencing over half bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      half_r  <= '0;
      timer_r <= 8'd0;
    end else if (load) begin
      busy_r  <= 1'b1;
      half_r  <= '0;
      timer_r <= 8'd0;
    end else if (take) begin
      if (res_last) begin
        busy_r <= 1'b0;
      end else begin
        half_r  <= half_r + sbt_pkg::HalfW'(1);
        timer_r <= (cfg.half_period == 8'd0) ? 8'd0 : cfg.half_period - 8'd1;
      end
    end else if (timer_r != 8'd0) begin
      timer_r <= timer_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cmd_r <= q_data;
  end

  // pin state of the current half bit
  always_comb begin
    out_item.cs_n_level = cmd_r.cs_n;
    out_item.last       = res_last;
    if (cmd_r.is_select) begin
      out_item.sck_level  = cfg.cpol;
      out_item.mosi_level = cmd_r.mosi_hold;
      out_item.rx_byte    = 8'd0;
      out_item.rx_valid   = 1'b0;
    end else begin
      out_item.sck_level  = cfg.cpol ^ cfg.cpha ^ half_r[0];
      out_item.mosi_level = cmd_r.tx_byte[bit_sel];
      out_item.rx_byte    = res_last ? cmd_r.miso_bits : 8'd0;
      out_item.rx_valid   = res_last;
    end
  end

endmodule

`default_nettype wire
